@@ hw/rtl/etok_pkg.sv @@
package etok_pkg;

    // token text buffer
    localparam int MAX_TEXT = 32;
    localparam int ADDR_W   = $clog2(MAX_TEXT);
    localparam int LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int KW_LEN   = 3;

    // item field widths
    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;
    localparam int POS_W  = 5;

    // character codes
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LC_V   = 8'h76;
    localparam logic [CHAR_W-1:0] CH_LC_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 4'd0,
        KIND_MINUS    = 4'd1,
        KIND_MULTIPLY = 4'd2,
        KIND_DIVIDE   = 4'd3,
        KIND_LPAREN   = 4'd4,
        KIND_RPAREN   = 4'd5,
        KIND_EQUAL    = 4'd6,
        KIND_COMMA    = 4'd7,
        KIND_FN       = 4'd8,
        KIND_VAR      = 4'd9,
        KIND_NAME     = 4'd10,
        KIND_NUMBER   = 4'd11,
        KIND_EOL      = 4'd12
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_HALT   = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_DOT,
        CLS_SPACE,
        CLS_OP,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_DRAIN,
        ST_BODY,
        ST_EOL
    } seq_state_t;

    typedef struct packed {
        token_kind_t       kind;
        logic [CHAR_W-1:0] text_char;
        logic [POS_W-1:0]  text_position;
        logic              token_last;
        logic              truncated;
    } token_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } text_req_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t r;
        if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z))
            r = CLS_LETTER;
        else if (c >= CH_ZERO && c <= CH_NINE)
            r = CLS_DIGIT;
        else if (c == CH_DOT)
            r = CLS_DOT;
        else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
            r = CLS_SPACE;
        else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                 c == CH_LPAREN || c == CH_RPAREN || c == CH_EQUAL || c == CH_COMMA)
            r = CLS_OP;
        else
            r = CLS_OTHER;
        return r;
    endfunction

    function automatic token_kind_t op_kind(input logic [CHAR_W-1:0] c);
        token_kind_t k;
        case (c)
            CH_PLUS:   k = KIND_ADD;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_MULTIPLY;
            CH_SLASH:  k = KIND_DIVIDE;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_EQUAL:  k = KIND_EQUAL;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_EOL;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/etok_in_if.sv @@
interface etok_in_if
    import etok_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

@@ hw/rtl/etok_out_if.sv @@
interface etok_out_if
    import etok_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] text_char;
    logic [POS_W-1:0]  text_position;
    logic              token_last;
    logic              truncated;

    modport source (output valid, output token_kind, output text_char,
                    output text_position, output token_last, output truncated,
                    input ready);
    modport sink   (input valid, input token_kind, input text_char,
                    input text_position, input token_last, input truncated,
                    output ready);
endinterface

@@ hw/rtl/etok_ram.sv @@
module etok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/etok_out_stage.sv @@
module etok_out_stage
    import etok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         emit,
    input  token_item_t  item,
    output logic         slot_free,
    etok_out_if.source   out_ch
);
    logic        valid_reg, valid_next;
    token_item_t item_reg, item_next;

    // slot frees up in the same cycle the held item transfers
    assign slot_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (emit && slot_free)
        begin
            valid_next = 1'b1;
            item_next  = item;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.token_kind    = item_reg.kind;
    assign out_ch.text_char     = item_reg.text_char;
    assign out_ch.text_position = item_reg.text_position;
    assign out_ch.token_last    = item_reg.token_last;
    assign out_ch.truncated     = item_reg.truncated;
endmodule

@@ hw/rtl/etok_ctrl.sv @@
module etok_ctrl
    import etok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              end_of_text,
    input  logic              slot_free,
    output logic              emit,
    output token_item_t       item,
    output text_req_t         text_req,
    input  logic [CHAR_W-1:0] text_rdata
);
    seq_state_t        state_reg, state_next;
    scan_mode_t        mode_reg, mode_next;
    char_class_t       cls_reg, cls_next;
    logic              dot_reg, dot_next;
    logic              ovf_reg, ovf_next;
    logic              tail_reg, tail_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              eot_reg, eot_next;
    logic [CHAR_W-1:0] kw_reg [KW_LEN];
    logic [CHAR_W-1:0] kw_next [KW_LEN];

    char_class_t       in_cls;
    logic              pre_flush;
    logic              flush_done;
    logic              token_open;
    logic              is_fn;
    logic              is_var;
    logic              drain_last;
    logic [LEN_W-1:0]  idx_ext;

    assign in_cls     = classify(char_in);
    assign token_open = (mode_reg == MODE_NAME) || (mode_reg == MODE_NUMBER);
    assign is_fn      = (mode_reg == MODE_NAME) && !ovf_reg && (len_reg == LEN_W'(2)) &&
                        (kw_reg[0] == CH_LC_F) && (kw_reg[1] == CH_LC_N);
    assign is_var     = (mode_reg == MODE_NAME) && !ovf_reg && (len_reg == LEN_W'(3)) &&
                        (kw_reg[0] == CH_LC_V) && (kw_reg[1] == CH_LC_A) &&
                        (kw_reg[2] == CH_LC_R);
    assign idx_ext    = LEN_W'(idx_reg);
    assign drain_last = (idx_ext + LEN_W'(1)) == len_reg;

    // does the incoming character end the pending token first
    always_comb
    begin
        case (in_cls)
            CLS_LETTER: pre_flush = (mode_reg == MODE_NUMBER);
            CLS_DIGIT:  pre_flush = (mode_reg == MODE_NAME);
            CLS_DOT:    pre_flush = (mode_reg == MODE_NAME) ||
                                    ((mode_reg == MODE_NUMBER) && dot_reg);
            default:    pre_flush = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cls_next   = cls_reg;
        dot_next   = dot_reg;
        ovf_next   = ovf_reg;
        tail_next  = tail_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        char_next  = char_reg;
        eot_next   = eot_reg;
        kw_next    = kw_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        item       = '{kind: KIND_EOL, text_char: CH_NUL, text_position: '0,
                       token_last: 1'b1, truncated: 1'b0};
        flush_done = 1'b0;
        text_req.we    = 1'b0;
        text_req.waddr = len_reg[ADDR_W-1:0];
        text_req.wdata = char_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    char_next = char_in;
                    eot_next  = end_of_text;
                    cls_next  = in_cls;
                    tail_next = 1'b0;
                    if (mode_reg == MODE_HALT)
                    begin
                        if (end_of_text)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else if (pre_flush)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_BODY;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (token_open && (is_fn || is_var))
                begin
                    emit      = 1'b1;
                    item.kind = is_fn ? KIND_FN : KIND_VAR;
                    if (slot_free)
                    begin
                        flush_done = 1'b1;
                    end
                end
                else if (token_open)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    flush_done = 1'b1;
                end
            end

            ST_DRAIN:
            begin
                emit               = 1'b1;
                item.kind          = (mode_reg == MODE_NAME) ? KIND_NAME : KIND_NUMBER;
                item.text_char     = text_rdata;
                item.text_position = POS_W'(idx_reg);
                item.token_last    = drain_last;
                item.truncated     = ovf_reg;
                if (slot_free)
                begin
                    if (drain_last)
                    begin
                        flush_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_BODY:
            begin
                case (cls_reg)
                    CLS_LETTER, CLS_DIGIT, CLS_DOT:
                    begin
                        mode_next = (cls_reg == CLS_LETTER) ? MODE_NAME : MODE_NUMBER;
                        if (cls_reg == CLS_DOT)
                        begin
                            dot_next = 1'b1;
                        end
                        if (len_reg < LEN_W'(MAX_TEXT))
                        begin
                            text_req.we = 1'b1;
                            len_next    = len_reg + LEN_W'(1);
                            for (int k = 0; k < KW_LEN; k++)
                            begin
                                if (len_reg == LEN_W'(k))
                                begin
                                    kw_next[k] = char_reg;
                                end
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    CLS_OP:
                    begin
                        emit           = 1'b1;
                        item.kind      = op_kind(char_reg);
                        item.text_char = char_reg;
                    end
                    CLS_OTHER:
                    begin
                        emit = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (!emit || slot_free)
                begin
                    if (cls_reg == CLS_OTHER)
                    begin
                        // eol already given: halt, or end of text releases at once
                        mode_next  = eot_reg ? MODE_IDLE : MODE_HALT;
                        state_next = ST_IDLE;
                    end
                    else if (eot_reg)
                    begin
                        tail_next  = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EOL:
            begin
                emit = 1'b1;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (flush_done)
        begin
            mode_next  = MODE_IDLE;
            dot_next   = 1'b0;
            len_next   = '0;
            ovf_next   = 1'b0;
            state_next = tail_reg ? ST_EOL : ST_BODY;
        end

        // read one ahead so the data lines up with idx_reg
        text_req.raddr = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_IDLE;
            cls_reg   <= CLS_SPACE;
            dot_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cls_reg   <= cls_next;
            dot_reg   <= dot_next;
            ovf_reg   <= ovf_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        eot_reg  <= eot_next;
        kw_reg   <= kw_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_TEXT))
        else $error("text length beyond buffer");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_W'(MAX_TEXT)))
        else $error("overflow flagged with room left");

    a_drain_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (mode_reg == MODE_NAME || mode_reg == MODE_NUMBER))
        else $error("draining with no open token");

    a_halt_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HALT) |-> (len_reg == '0 && !ovf_reg))
        else $error("halted with buffered text");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (idx_ext < len_reg))
        else $error("drain index past text length");
endmodule

@@ hw/rtl/expression_tokenizer.sv @@
// expression tokenizer: one character per input transfer, token items out
// a character needing no flush is accepted, then takes one step; a flush adds a flush step,
// and draining a name or number then adds a step per stored character (a keyword adds none)
// end of text adds a flush and an eol step, an other character with it adds neither; results
// leave through the output register, loaded at their step; stalls on out_ch extend steps
// reset (rst_n low, asynchronous) clears sequencer, scan mode and output valid; no store clear
module expression_tokenizer
    import etok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    etok_in_if.sink   in_ch,
    etok_out_if.source out_ch
);
    // sequencer to output register
    logic              emit;
    token_item_t       item;
    logic              slot_free;

    // token text store, written at the fill count, read by the drain index
    text_req_t         text_req;
    logic [CHAR_W-1:0] text_rdata;

    // classification, buffering and token emission under one sequencer;
    // the buffer drain walks the store one character a cycle while the output slot is free
    etok_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .char_in     (in_ch.char_in),
        .end_of_text (in_ch.end_of_text),
        .slot_free   (slot_free),
        .emit        (emit),
        .item        (item),
        .text_req    (text_req),
        .text_rdata  (text_rdata)
    );

    // registered read, address presented in the cycle before its data is used
    etok_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_req.we),
        .waddr (text_req.waddr),
        .wdata (text_req.wdata),
        .raddr (text_req.raddr),
        .rdata (text_rdata)
    );

    // output register: a waiting result does not block the next load once taken
    etok_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .item      (item),
        .slot_free (slot_free),
        .out_ch    (out_ch)
    );
endmodule

@@ sim/expression_tokenizer_tb.sv @@
`timescale 1ns / 100ps

module expression_tokenizer_tb
    import etok_pkg::*;
();

    // clock, reset and the two channels
    logic clk = 1'b0;
    logic rst_n;

    etok_in_if  in_ch ();
    etok_out_if out_ch ();

    expression_tokenizer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lexer shadow state, kept in step with every accepted character
    scan_mode_t        lex_mode;
    logic              lex_dot;
    logic [CHAR_W-1:0] lex_text [MAX_TEXT];
    int                lex_len;
    logic              lex_ovf;

    // token items still owed by the block, oldest first
    token_item_t token_queue [$];

    // characters of the expression being built
    logic [CHAR_W-1:0] text_buf [$];

    // run bookkeeping
    int  mismatch_count  = 0;
    int  text_items      = 0;
    int  ignored_items   = 0;
    int  items_checked   = 0;
    int  truncated_count = 0;
    int  halt_count      = 0;
    bit  no_idle         = 1'b0;

    // the eight single-character operators, in token kind order
    localparam logic [CHAR_W-1:0] OP_CHARS [8] = '{
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
        CH_LPAREN, CH_RPAREN, CH_EQUAL, CH_COMMA
    };

    // ------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------

    function automatic void queue_token(token_kind_t k, logic [CHAR_W-1:0] ch, int pos,
                                        logic last, logic trunc);
        token_item_t t;
        t.kind          = k;
        t.text_char     = ch;
        t.text_position = pos[POS_W-1:0];
        t.token_last    = last;
        t.truncated     = trunc;
        token_queue.insert(token_queue.size(), t);
    endfunction

    function automatic void add_char(logic [CHAR_W-1:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void reset_token();
        lex_mode = MODE_IDLE;
        lex_dot  = 1'b0;
        lex_len  = 0;
        lex_ovf  = 1'b0;
    endfunction

    function automatic void store_char(logic [CHAR_W-1:0] c);
        if (lex_len < MAX_TEXT)
        begin
            lex_text[lex_len] = c;
            lex_len++;
        end
        else
            lex_ovf = 1'b1;
    endfunction

    // pending name or number goes out, keyword check first
    function automatic void end_token();
        token_kind_t k;
        bit          is_name;
        is_name = (lex_mode == MODE_NAME);
        if (lex_mode == MODE_NAME || lex_mode == MODE_NUMBER)
        begin
            k = is_name ? KIND_NAME : KIND_NUMBER;
            // a cut text is never a keyword
            if (is_name && !lex_ovf && lex_len == 2 &&
                lex_text[0] == CH_LC_F && lex_text[1] == CH_LC_N)
                queue_token(KIND_FN, CH_NUL, 0, 1'b1, 1'b0);
            else if (is_name && !lex_ovf && lex_len == 3 && lex_text[0] == CH_LC_V &&
                     lex_text[1] == CH_LC_A && lex_text[2] == CH_LC_R)
                queue_token(KIND_VAR, CH_NUL, 0, 1'b1, 1'b0);
            else
            begin
                for (int i = 0; i < lex_len; i++)
                    queue_token(k, lex_text[i], i, (i == lex_len - 1), lex_ovf);
                if (lex_ovf)
                    truncated_count++;
            end
        end
        if (lex_mode != MODE_HALT)
            reset_token();
    endfunction

    // returns 0 when the character is swallowed in halted mode
    function automatic bit lex_char(logic [CHAR_W-1:0] c, logic eot);
        bit alpha_hit;
        bit numeral_hit;
        bit is_blank;
        bit eol_sent;
        int op_idx;
        alpha_hit   = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
        numeral_hit = (c >= CH_ZERO && c <= CH_NINE);
        is_blank    = (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
        eol_sent    = 1'b0;
        op_idx      = -1;
        for (int k = 0; k < 8; k++)
            if (c == OP_CHARS[k])
                op_idx = k;

        if (lex_mode == MODE_HALT)
        begin
            // end of text releases the halt without another eol
            if (eot)
                reset_token();
            return 1'b0;
        end

        if (alpha_hit)
        begin
            if (lex_mode == MODE_NUMBER)
                end_token();
            lex_mode = MODE_NAME;
            store_char(c);
        end
        else if (numeral_hit)
        begin
            if (lex_mode == MODE_NAME)
                end_token();
            lex_mode = MODE_NUMBER;
            store_char(c);
        end
        else if (c == CH_DOT)
        begin
            // second dot closes the number and opens a new one
            if (lex_mode == MODE_NAME || (lex_mode == MODE_NUMBER && lex_dot))
                end_token();
            lex_mode = MODE_NUMBER;
            lex_dot  = 1'b1;
            store_char(c);
        end
        else if (is_blank)
            end_token();
        else if (op_idx >= 0)
        begin
            end_token();
            queue_token(token_kind_t'(op_idx), c, 0, 1'b1, 1'b0);
        end
        else
        begin
            // anything else: flush, eol, then ignore until end of text
            end_token();
            queue_token(KIND_EOL, CH_NUL, 0, 1'b1, 1'b0);
            eol_sent = 1'b1;
            lex_mode = MODE_HALT;
            halt_count++;
        end

        if (eot)
        begin
            if (!eol_sent)
            begin
                end_token();
                queue_token(KIND_EOL, CH_NUL, 0, 1'b1, 1'b0);
            end
            reset_token();
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // input side: one character per transfer
    // ------------------------------------------------------------------

    // called just after a rising edge; valid stays high when the next
    // character follows without a gap, so it is never dropped and raised
    // within one step
    task automatic send_char(logic [CHAR_W-1:0] c, logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_in     <= c;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // transfer taken at this edge
        if (lex_char(c, eot))
            text_items++;
        else
            ignored_items++;
    endtask

    task automatic send_text(string s, bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [CHAR_W-1:0] any_letter();
        if ($urandom_range(0, 1))
            return CH_LC_A + CHAR_W'($urandom_range(0, 25));
        return CH_UC_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] any_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and in-order checking
    // ------------------------------------------------------------------

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_tokens
        token_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (token_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected token item kind %0d char %02h pos %0d last %0b %s %0b",
                         $time, out_ch.token_kind, out_ch.text_char, out_ch.text_position,
                         out_ch.token_last, "trunc", out_ch.truncated);
            end
            else
            begin
                want = token_queue.pop_front();
                items_checked++;
                if (out_ch.token_kind !== want.kind || out_ch.text_char !== want.text_char ||
                    out_ch.text_position !== want.text_position ||
                    out_ch.token_last !== want.token_last ||
                    out_ch.truncated !== want.truncated)
                begin
                    mismatch_count++;
                    $display("%0t: token item mismatch, expected kind %0d char %02h pos %0d %s",
                             $time, want.kind, want.text_char, want.text_position, "");
                    $display("%0t:     expected last %0b trunc %0b", $time,
                             want.token_last, want.truncated);
                    $display("%0t:     actual kind %0d char %02h pos %0d last %0b trunc %0b",
                             $time, out_ch.token_kind, out_ch.text_char,
                             out_ch.text_position, out_ch.token_last, out_ch.truncated);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // keywords, case sensitivity, every operator but ')' and every blank
    task automatic test_keywords_and_ops();
        send_text("fn+var(Var\t", 1'b0);
        send_text("-*/=, \r\n", 1'b0);
    endtask

    // name to number switch, double dot split, letter range edges
    task automatic test_numbers_and_dots();
        send_text("x9..)AZ\t", 1'b0);
        send_text("z0", 1'b1);
    endtask

    // other characters, halted mode and end of text in each mode
    task automatic test_halt_and_end();
        send_text("7", 1'b0);
        send_char(8'hFF, 1'b0);        // number flushed, eol, halt
        send_char(CH_LC_A, 1'b0);      // swallowed
        send_char(CH_PLUS, 1'b1);      // end of text leaves halt silently
        send_char(CH_DOT, 1'b1);       // lone dot number then eol
        send_char(CH_NUL, 1'b1);       // nul is other: only one eol
        send_char(8'h80, 1'b0);
        send_text("q", 1'b1);
        send_text("ab ", 1'b1);        // blank with end of text
    endtask

    // names and numbers around and past the text buffer size
    task automatic test_long_text();
        for (int i = 0; i < MAX_TEXT; i++)
            send_char(any_letter(), 1'b0);
        send_char(CH_SPACE, 1'b0);
        // back to back so the long drain meets a busy input side
        no_idle = 1'b1;
        for (int i = 0; i <= MAX_TEXT; i++)
            send_char(any_digit(), i == MAX_TEXT);
        no_idle = 1'b0;
        // cut keyword prefix stays a name
        send_text("var", 1'b0);
        for (int i = 0; i < MAX_TEXT + 5; i++)
            send_char(any_letter(), 1'b0);
        send_char(CH_PLUS, 1'b1);
    endtask

    // well-formed expressions with random content, some noise mixed in
    task automatic test_random_expressions(int target);
        int n_tok;
        int pick;
        int len;
        while (text_items < target)
        begin
            text_buf.delete();
            no_idle = ($urandom_range(0, 4) == 0);
            n_tok   = $urandom_range(1, 10);
            for (int t = 0; t < n_tok; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    case ($urandom_range(0, 5))
                        0: begin add_char(CH_LC_F); add_char(CH_LC_N); end
                        1:
                        begin
                            add_char(CH_LC_V);
                            add_char(CH_LC_A);
                            add_char(CH_LC_R);
                        end
                        default:
                        begin
                            len = $urandom_range(1, 6);
                            repeat (len) add_char(any_letter());
                        end
                    endcase
                end
                else if (pick < 55)
                begin
                    len = $urandom_range(1, 5);
                    repeat (len)
                        add_char(($urandom_range(0, 4) == 0) ? CH_DOT : any_digit());
                end
                else if (pick < 80)
                    add_char(OP_CHARS[$urandom_range(0, 7)]);
                else if (pick < 92)
                begin
                    case ($urandom_range(0, 3))
                        0: add_char(CH_SPACE);
                        1: add_char(CH_TAB);
                        2: add_char(CH_CR);
                        default: add_char(CH_LF);
                    endcase
                end
                else if (pick < 96)
                begin
                    // occasional token near the buffer limit
                    len = $urandom_range(MAX_TEXT - 2, MAX_TEXT + 4);
                    if ($urandom_range(0, 1))
                        repeat (len) add_char(any_letter());
                    else
                        repeat (len) add_char(any_digit());
                end
                else
                    add_char(CHAR_W'($urandom_range(0, 255)));
            end
            for (int i = 0; i < text_buf.size(); i++)
                send_char(text_buf[i], i == text_buf.size() - 1);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        int waited;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_in     = CH_NUL;
        in_ch.end_of_text = 1'b0;
        reset_token();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_keywords_and_ops();
        test_numbers_and_dots();
        test_halt_and_end();
        test_long_text();
        test_random_expressions(330);
        in_ch.valid <= 1'b0;

        // let the last tokens drain, then allow a little tail for strays
        waited = 0;
        while (token_queue.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * MAX_TEXT + 10) @(posedge clk);
        if (token_queue.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d token items never arrived", $time, token_queue.size());
        end

        $display("characters lexed %0d, swallowed while halted %0d, token items checked %0d",
                 text_items, ignored_items, items_checked);
        $display("truncated tokens %0d, halts on other characters %0d, mismatches %0d",
                 truncated_count, halt_count, mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/etok_pkg.sv
hw/rtl/etok_in_if.sv
hw/rtl/etok_out_if.sv
hw/rtl/etok_ram.sv
hw/rtl/etok_out_stage.sv
hw/rtl/etok_ctrl.sv
hw/rtl/expression_tokenizer.sv
sim/expression_tokenizer_tb.sv
